[design/tmcw_pkg.sv]
// Package for the text mode console writer.
// Request type codes, special character codes and stream bus widths.
// No dependencies.
package tmcw_pkg;

   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 2;

   localparam int CELL_W = 16;

   typedef logic [1:0] req_kind_type;

   localparam req_kind_type REQ_PRINT = 2'd0;
   localparam req_kind_type REQ_INIT  = 2'd1;
   localparam req_kind_type REQ_READ  = 2'd2;

   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] ATTR_DEFAULT   = 8'h0F;

   // One latched request, unpacked from the slave-side stream.
   typedef struct packed {
      req_kind_type kind;
      logic [7:0]   char_code;
      logic [7:0]   char_attr;
      logic [6:0]   read_col;
      logic [4:0]   read_row;
   } req_fields_type;

endpackage

[design/tmcw_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Used for the console cell store. No dependencies.
module tmcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/text_mode_console_writer_top.sv]
// Top level of the text mode console writer: request sequencer, cursor and result register.
// Depends on tmcw_pkg and tmcw_ram.
//
// Usage:
// Requests arrive on the req_ stream: req_tuser carries the request type (print, initialise,
// read), req_tdata the character, attribute and read position. Each request gives exactly one
// result on the rsp_ stream with the read cell, the cursor after the request and two flags.
// Requests are handled one at a time by a small sequencer driving one address adder and a
// single cell RAM; req_tready is high only while the sequencer is idle.
// A print, an ignored print, a read out of range or the unused request type goes from the
// execute step straight to the result; a backspace within a row adds the cell write, a newline
// or wrap that does not scroll adds the row step, a read adds the address and data steps, and
// a backspace that steps back to the row above adds the row step back and the cell write. A
// scroll walks the cell RAM, reading and writing each moved cell, then clears the bottom row
// at one cell a cycle. An initialise request clears the RAM at one cell a cycle. The next
// request can be taken in the cycle after the previous result is loaded.
// After reset the block runs a clearing pass over all SCREEN_ROWS*SCREEN_COLS cells before it
// first raises req_tready; prints stay ignored until an initialise request has been handled.
// A finished result waits in the output register while the receiver stalls; the next request
// is still accepted and processed, and its result waits until the register is free.
module text_mode_console_writer_top #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: char_code[7:0], char_attr[15:8], read_col[22:16], read_row[27:23], zero
   input  logic [tmcw_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_tuser: req_type[1:0]
   input  logic [tmcw_pkg::REQ_TUSER_W-1:0]    req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: cell_char[7:0], cell_attr[15:8], cursor_col[22:16], cursor_row[27:23], zero
   output logic [tmcw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // rsp_tuser: scrolled[0], ignored[1]
   output logic [tmcw_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);

   import tmcw_pkg::*;

   localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(SCREEN_COLS);
   localparam int ROW_W      = $clog2(SCREEN_ROWS);

   localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(SCREEN_COLS);
   localparam logic [ADDR_W-1:0] ROW_BACK   = ADDR_W'((1 << ADDR_W) - SCREEN_COLS);
   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] LAST_MOVED = ADDR_W'(CELL_COUNT - SCREEN_COLS - 1);
   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_COLS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_EXEC    = 4'd1;
   localparam logic [3:0] ST_NEWLINE = 4'd2;
   localparam logic [3:0] ST_BSUP    = 4'd3;
   localparam logic [3:0] ST_BSWR    = 4'd4;
   localparam logic [3:0] ST_RDADDR  = 4'd5;
   localparam logic [3:0] ST_RDDATA  = 4'd6;
   localparam logic [3:0] ST_SC_RD   = 4'd7;
   localparam logic [3:0] ST_SC_WR   = 4'd8;
   localparam logic [3:0] ST_CLEAR   = 4'd9;
   localparam logic [3:0] ST_DONE    = 4'd10;

   // Control state
   logic [3:0]        state_ff, state_in;
   logic              boot_ff, boot_in;
   logic              ready_ff, ready_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload
   req_fields_type    req_ff, req_in;
   logic [ADDR_W-1:0] rd_base_ff, rd_base_in;
   logic [7:0]        cchar_ff, cchar_in;
   logic [7:0]        cattr_ff, cattr_in;
   logic              scrolled_ff, scrolled_in;
   logic              ignored_ff, ignored_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic [7:0]        rsp_attr_ff, rsp_attr_in;
   logic [6:0]        rsp_col_ff, rsp_col_in;
   logic [4:0]        rsp_row_ff, rsp_row_in;
   logic              rsp_scr_ff, rsp_scr_in;
   logic              rsp_ign_ff, rsp_ign_in;

   // Shared address adder
   logic [ADDR_W-1:0] add_a, add_b, add_sum;

   // Cell RAM port
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] rd_data;

   logic [31:0]       col_wide, row_wide;
   logic              read_in_range;
   logic [7:0]        print_attr;
   logic              rsp_load;

   tmcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign col_wide      = 32'(col_ff);
   assign row_wide      = 32'(row_ff);
   assign read_in_range = (32'(req_ff.read_col) < SCREEN_COLS) &&
                          (32'(req_ff.read_row) < SCREEN_ROWS);
   assign print_attr    = (req_ff.char_attr == 8'd0) ? ATTR_DEFAULT : req_ff.char_attr;
   assign rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Operand selection for the one adder that the address steps share.
   always_comb begin
      add_a = '0;
      add_b = '0;
      case (state_ff)
         ST_EXEC, ST_BSWR: begin
            add_a = base_ff;
            add_b = ADDR_W'(col_ff);
         end
         ST_BSUP: begin
            add_a = base_ff;
            add_b = ROW_BACK;
         end
         ST_NEWLINE: begin
            add_a = base_ff;
            add_b = ROW_STEP;
         end
         ST_RDADDR: begin
            add_a = rd_base_ff;
            add_b = ADDR_W'(req_ff.read_col);
         end
         ST_SC_RD: begin
            add_a = sweep_ff;
            add_b = ROW_STEP;
         end
         ST_SC_WR, ST_CLEAR: begin
            add_a = sweep_ff;
            add_b = ADDR_W'(1);
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
   end

   assign add_sum = add_a + add_b;

   always_comb begin
      state_in     = state_ff;
      boot_in      = boot_ff;
      ready_in     = ready_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      sweep_in     = sweep_ff;
      req_in       = req_ff;
      rd_base_in   = rd_base_ff;
      cchar_in     = cchar_ff;
      cattr_in     = cattr_ff;
      scrolled_in  = scrolled_ff;
      ignored_in   = ignored_ff;
      wr_en        = 1'b0;
      wr_addr      = add_sum;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = add_sum;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               req_in.kind      = req_tuser[1:0];
               req_in.char_code = req_tdata[7:0];
               req_in.char_attr = req_tdata[15:8];
               req_in.read_col  = req_tdata[22:16];
               req_in.read_row  = req_tdata[27:23];
               cchar_in         = 8'd0;
               cattr_in         = 8'd0;
               scrolled_in      = 1'b0;
               ignored_in       = 1'b0;
               state_in         = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (req_ff.kind)
               REQ_PRINT: begin
                  if (!ready_ff) begin
                     ignored_in = 1'b1;
                  end else if (req_ff.char_code == CHAR_NEWLINE) begin
                     state_in = ST_NEWLINE;
                  end else if (req_ff.char_code == CHAR_BACKSPACE) begin
                     if (col_ff != '0) begin
                        col_in   = col_ff - 1'b1;
                        state_in = ST_BSWR;
                     end else if (row_ff != '0) begin
                        row_in   = row_ff - 1'b1;
                        col_in   = LAST_COL;
                        state_in = ST_BSUP;
                     end
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = {print_attr, req_ff.char_code};
                     if (col_ff == LAST_COL) begin
                        state_in = ST_NEWLINE;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
               end
               REQ_INIT: begin
                  sweep_in = '0;
                  state_in = ST_CLEAR;
               end
               REQ_READ: begin
                  if (read_in_range) begin
                     rd_base_in = ADDR_W'(32'(req_ff.read_row) * SCREEN_COLS);
                     state_in   = ST_RDADDR;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_NEWLINE: begin
            col_in = '0;
            if (row_ff == LAST_ROW) begin
               // The cursor already sits on the bottom row; only the cells move.
               scrolled_in = 1'b1;
               sweep_in    = '0;
               state_in    = ST_SC_RD;
            end else begin
               row_in   = row_ff + 1'b1;
               base_in  = add_sum;
               state_in = ST_DONE;
            end
         end
         ST_BSUP: begin
            base_in  = add_sum;
            state_in = ST_BSWR;
         end
         ST_BSWR: begin
            wr_en    = 1'b1;
            state_in = ST_DONE;
         end
         ST_RDADDR: begin
            rd_en    = 1'b1;
            state_in = ST_RDDATA;
         end
         ST_RDDATA: begin
            cchar_in = rd_data[7:0];
            cattr_in = rd_data[15:8];
            state_in = ST_DONE;
         end
         ST_SC_RD: begin
            rd_en    = 1'b1;
            state_in = ST_SC_WR;
         end
         ST_SC_WR: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = rd_data;
            sweep_in = add_sum;
            // Once the last moved cell is written, the bottom row is cleared by the same sweep.
            state_in = (sweep_ff == LAST_MOVED) ? ST_CLEAR : ST_SC_RD;
         end
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            sweep_in = add_sum;
            if (sweep_ff == LAST_CELL) begin
               if (boot_ff) begin
                  boot_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  ready_in = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loaded from the finished request, held while the receiver stalls.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_scr_in   = rsp_scr_ff;
      rsp_ign_in   = rsp_ign_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = cchar_ff;
         rsp_attr_in  = cattr_ff;
         rsp_col_in   = col_wide[6:0];
         rsp_row_in   = row_wide[4:0];
         rsp_scr_in   = scrolled_ff;
         rsp_ign_in   = ignored_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         boot_ff      <= 1'b1;
         ready_ff     <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         ready_ff     <= ready_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rd_base_ff  <= rd_base_in;
      cchar_ff    <= cchar_in;
      cattr_ff    <= cattr_in;
      scrolled_ff <= scrolled_in;
      ignored_ff  <= ignored_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_scr_ff  <= rsp_scr_in;
      rsp_ign_ff  <= rsp_ign_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_row_ff, rsp_col_ff, rsp_attr_ff, rsp_char_ff};
   assign rsp_tuser  = {rsp_ign_ff, rsp_scr_ff};

endmodule
